/* rtl/core/ordered_region_waypoint_filter_unit_defines.svh */
// assertion macros for the ordered region waypoint filter
// used by the top level only, needs clk_i and rst_ni in scope
`ifndef ORDERED_REGION_WAYPOINT_FILTER_UNIT_DEFINES_SVH
`define ORDERED_REGION_WAYPOINT_FILTER_UNIT_DEFINES_SVH

// checked property, off while reset is applied
`define ORWF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// checked property, also during reset
`define ORWF_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

/* rtl/core/orwf_pkg.sv */
// package for the ordered region waypoint filter
// types, field widths and register indexes; no dependencies
`timescale 1ns / 1ps

package orwf_pkg;

  localparam int unsigned LabelW      = 16;
  localparam int unsigned CountCfgW   = 3;
  localparam int unsigned CfgIndexW   = 3;
  localparam int unsigned KeepStartW  = 12;
  localparam int unsigned KeepCountW  = 13;
  localparam int unsigned OutDataW    = 32;

  typedef enum logic [CfgIndexW-1:0] {
    REG_LABEL_COUNT = 3'd0,
    REG_CUT_MODE    = 3'd1,
    REG_LABEL_A     = 3'd2,
    REG_LABEL_B     = 3'd3,
    REG_LABEL_C     = 3'd4,
    REG_LABEL_D     = 3'd5,
    REG_LABEL_E     = 3'd6,
    REG_LABEL_F     = 3'd7
  } cfg_reg_e;

  typedef enum logic [1:0] {
    PH_SEEK   = 2'd0,
    PH_INSIDE = 2'd1,
    PH_LEFT   = 2'd2,
    PH_DONE   = 2'd3
  } phase_e;

  typedef struct packed {
    logic                  overlong;
    logic [KeepCountW-1:0] keep_count;
    logic [KeepStartW-1:0] keep_start;
    logic                  accepted;
  } result_t;

endpackage

/* rtl/core/ordered_region_waypoint_filter_unit.sv */
// ordered region waypoint filter, top level
// depends on orwf_pkg and ordered_region_waypoint_filter_unit_defines.svh
//
//   channel   dir   beat content (low bits first)
//   s_axis    in    tdata: voxel_label[15:0]; tlast: last_point
//   m_axis    out   tdata: accepted, keep_start[11:0], keep_count[12:0], overlong
//   cfg       in    cfg_index_i: register index; cfg_data_i: value
//
// one beat per cycle while s_axis_tready is high; path state updates as the beat is taken
// a result is registered when the last beat of a path is taken
// s_axis_tready drops only while a result waits and m_axis_tready is low
// cfg always ready; reset clears path state, valid flag, labels and cut mode; count is 2
`timescale 1ns / 1ps
`include "ordered_region_waypoint_filter_unit_defines.svh"

module ordered_region_waypoint_filter_unit
  import orwf_pkg::*;
#(
  parameter int unsigned MAX_POINTS = 4096,
  parameter int unsigned MAX_LABELS = 6
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [LabelW-1:0]    s_axis_tdata,  // voxel_label
  input  logic                 s_axis_tlast,  // last_point
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [OutDataW-1:0]  m_axis_tdata,  // accepted, keep_start, keep_count, overlong
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CfgIndexW-1:0] cfg_index_i,
  input  logic [LabelW-1:0]    cfg_data_i
);

  localparam int unsigned PiW = $clog2(MAX_POINTS + 1);
  localparam int unsigned IxW = $clog2(MAX_POINTS);

  // configuration
  logic [CountCfgW-1:0] label_count_q;
  logic                 cut_mode_q;
  logic [LabelW-1:0]    label_q [MAX_LABELS];

  // path state
  phase_e               phase_q, phase_d;
  logic [CountCfgW-1:0] pos_q, pos_d;
  logic [IxW-1:0]       exit_q, exit_d;
  logic [IxW-1:0]       match_q, match_d;
  logic [PiW-1:0]       pidx_q, pidx_d;
  logic                 ovf_q, ovf_d;

  // result slot
  logic                 out_valid_q;
  result_t              out_q, res_d;

  logic                 in_fire;
  logic                 sat;
  logic [IxW-1:0]       idx;
  logic [CountCfgW-1:0] n_eff;
  logic [CountCfgW-1:0] pos_sel;
  logic [LabelW-1:0]    sel_label;
  logic                 hit_first;
  logic                 hit_next;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OutDataW'(out_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      label_count_q <= CountCfgW'(2);
      cut_mode_q    <= 1'b0;
      for (int i = 0; i < MAX_LABELS; i++) begin
        label_q[i] <= '0;
      end
    end else if (cfg_valid_i) begin
      if (cfg_index_i == REG_LABEL_COUNT) begin
        label_count_q <= cfg_data_i[CountCfgW-1:0];
      end
      if (cfg_index_i == REG_CUT_MODE) begin
        cut_mode_q <= cfg_data_i[0];
      end
      for (int i = 0; i < MAX_LABELS; i++) begin
        if (cfg_index_i == CfgIndexW'(int'(REG_LABEL_A) + i)) begin
          label_q[i] <= cfg_data_i;
        end
      end
    end
  end

  // effective label count and the label wanted next
  always_comb begin
    n_eff = label_count_q;
    if (label_count_q < CountCfgW'(2)) begin
      n_eff = CountCfgW'(2);
    end else if (label_count_q > CountCfgW'(MAX_LABELS)) begin
      n_eff = CountCfgW'(MAX_LABELS);
    end
    pos_sel = (pos_q > CountCfgW'(MAX_LABELS - 1)) ? CountCfgW'(MAX_LABELS - 1) : pos_q;
    sel_label = label_q[0];
    for (int i = 0; i < MAX_LABELS; i++) begin
      if (pos_sel == CountCfgW'(i)) begin
        sel_label = label_q[i];
      end
    end
  end

  assign sat       = (pidx_q >= PiW'(MAX_POINTS));
  assign idx       = sat ? IxW'(MAX_POINTS - 1) : pidx_q[IxW-1:0];
  assign hit_first = (s_axis_tdata == label_q[0]);
  assign hit_next  = (s_axis_tdata == sel_label);

  // next path state
  always_comb begin
    phase_d = phase_q;
    pos_d   = pos_q;
    exit_d  = exit_q;
    match_d = match_q;
    pidx_d  = sat ? pidx_q : pidx_q + 1'b1;
    ovf_d   = ovf_q || sat;
    unique case (phase_q)
      PH_SEEK: begin
        if (hit_first) begin
          phase_d = PH_INSIDE;
          pos_d   = CountCfgW'(1);
        end
      end
      PH_INSIDE, PH_LEFT: begin
        if (phase_q == PH_INSIDE && !hit_first) begin
          phase_d = PH_LEFT;
          exit_d  = idx;
        end
        if (hit_next) begin
          if ({1'b0, pos_q} + 1'b1 >= {1'b0, n_eff}) begin
            phase_d = PH_DONE;
            match_d = idx;
          end else begin
            pos_d = pos_q + 1'b1;
          end
        end
      end
      PH_DONE: begin
      end
      default: begin
        phase_d = PH_SEEK;
      end
    endcase
  end

  // result of a path ending on this beat
  always_comb begin
    res_d          = '0;
    res_d.accepted = (phase_d == PH_DONE);
    res_d.overlong = ovf_d;
    if (res_d.accepted) begin
      if (cut_mode_q) begin
        res_d.keep_start = KeepStartW'(32'(exit_d));
        if (match_d >= exit_d) begin
          res_d.keep_count = KeepCountW'(32'(match_d - exit_d));
        end
      end else begin
        res_d.keep_count = KeepCountW'(32'(pidx_d));
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_SEEK;
      pos_q   <= '0;
      exit_q  <= '0;
      match_q <= '0;
      pidx_q  <= '0;
      ovf_q   <= 1'b0;
    end else if (in_fire) begin
      if (s_axis_tlast) begin
        phase_q <= PH_SEEK;
        pos_q   <= '0;
        exit_q  <= '0;
        match_q <= '0;
        pidx_q  <= '0;
        ovf_q   <= 1'b0;
      end else begin
        phase_q <= phase_d;
        pos_q   <= pos_d;
        exit_q  <= exit_d;
        match_q <= match_d;
        pidx_q  <= pidx_d;
        ovf_q   <= ovf_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire && s_axis_tlast) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && s_axis_tlast) begin
      out_q <= res_d;
    end
  end

  `ORWF_ASSERT(a_path_clear, in_fire && s_axis_tlast |=> phase_q == PH_SEEK && pidx_q == '0, "path state not cleared after last beat")
  `ORWF_ASSERT(a_result_up, in_fire && s_axis_tlast |=> out_valid_q, "no result after last beat")
  `ORWF_ASSERT(a_done_holds, in_fire && !s_axis_tlast && phase_q == PH_DONE |=> phase_q == PH_DONE, "accepted path left done phase")
  `ORWF_ASSERT(a_reject_zero, out_valid_q && !out_q.accepted |-> out_q.keep_start == '0 && out_q.keep_count == '0, "rejected path with nonzero span")

endmodule

/* tb/sv/testbench.sv */
// self-checking bench for ordered_region_waypoint_filter_unit: streams labeled paths,
// predicts each path verdict in the bench and checks every output beat field by field
// depends on orwf_pkg and the rtl top level only
`timescale 1ns / 1ps

module testbench;
  import orwf_pkg::*;

  localparam int unsigned MaxPoints  = 4096;
  localparam int unsigned HoldCycles = 300;

  typedef struct {
    logic [LabelW-1:0] label;
    bit                last;
    int unsigned       gap;
  } point_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [LabelW-1:0]    s_axis_tdata = '0;
  logic                 s_axis_tlast = 1'b0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [OutDataW-1:0]  m_axis_tdata;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [CfgIndexW-1:0] cfg_index_i = '0;
  logic [LabelW-1:0]    cfg_data_i = '0;

  // register mirror
  logic [CountCfgW-1:0] cnt_reg = 3'd2;
  bit                   cut_reg = 1'b0;
  logic [LabelW-1:0]    lbl_reg [6] = '{default: '0};

  // path tracking state
  phase_e      path_phase = PH_SEEK;
  int unsigned want_pos = 0;
  int unsigned exit_idx = 0;
  int unsigned pt_idx = 0;
  int unsigned match_idx = 0;
  bit          ovf = 1'b0;

  point_t      point_q [$];
  result_t     verdict_q [$];
  int unsigned tx_idle_pct = 30;
  int unsigned rx_idle_pct = 30;
  int unsigned gap_cnt = 0;
  int unsigned stall_left = 0;
  bit          hold_req = 1'b0;
  bit          hold_taken = 1'b0;
  int unsigned points_queued = 0;
  int unsigned points_sent = 0;
  int unsigned verdicts_seen = 0;
  int unsigned accepted_seen = 0;
  int unsigned overlong_seen = 0;
  int unsigned errors = 0;

  ordered_region_waypoint_filter_unit uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #10 clk_i = ~clk_i;

  function automatic int unsigned eff_labels();
    if (cnt_reg < 2) return 2;
    if (cnt_reg > 6) return 6;
    return cnt_reg;
  endfunction

  function automatic int unsigned draw_wait(int unsigned pct);
    return ($urandom_range(0, 99) < pct) ? $urandom_range(0, 18) : 0;
  endfunction

  function automatic void track_waypoint(logic [LabelW-1:0] v, bit last);
    int unsigned n;
    int unsigned idx;
    int unsigned pos;
    result_t     r;
    n = eff_labels();
    if (pt_idx >= MaxPoints) begin
      ovf = 1'b1;
      idx = MaxPoints - 1;
    end else begin
      idx = pt_idx;
      pt_idx++;
    end
    case (path_phase)
      PH_SEEK: begin
        if (v == lbl_reg[0]) begin
          path_phase = PH_INSIDE;
          want_pos = 1;
        end
      end
      PH_INSIDE, PH_LEFT: begin
        if (path_phase == PH_INSIDE && v != lbl_reg[0]) begin
          path_phase = PH_LEFT;
          exit_idx = idx;
        end
        pos = (want_pos > 5) ? 5 : want_pos;
        if (v == lbl_reg[pos]) begin
          if (want_pos + 1 >= n) begin
            path_phase = PH_DONE;
            match_idx = idx;
          end else begin
            want_pos++;
          end
        end
      end
      default: ;
    endcase
    if (last) begin
      r = '0;
      r.accepted = (path_phase == PH_DONE);
      if (r.accepted) begin
        if (cut_reg) begin
          r.keep_start = KeepStartW'(exit_idx);
          r.keep_count = (match_idx >= exit_idx) ? KeepCountW'(match_idx - exit_idx) : '0;
        end else begin
          r.keep_count = KeepCountW'(pt_idx);
        end
      end
      r.overlong = ovf;
      verdict_q.push_back(r);
      path_phase = PH_SEEK;
      want_pos = 0;
      exit_idx = 0;
      pt_idx = 0;
      match_idx = 0;
      ovf = 1'b0;
    end
  endfunction

  // sender: one beat per queued point, idle gap drawn per point
  always @(posedge clk_i or negedge rst_ni) begin : sender
    point_t nxt;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata <= '0;
      s_axis_tlast <= 1'b0;
      gap_cnt <= 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        track_waypoint(s_axis_tdata, s_axis_tlast);
        points_sent++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (point_q.size() != 0 && gap_cnt >= point_q[0].gap) begin
          nxt = point_q.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= nxt.label;
          s_axis_tlast <= nxt.last;
          gap_cnt <= 0;
        end else begin
          s_axis_tvalid <= 1'b0;
          if (point_q.size() != 0) gap_cnt <= gap_cnt + 1;
        end
      end
    end
  end

  // receiver: checks each verdict beat, stalls at random
  always @(posedge clk_i or negedge rst_ni) begin : receiver
    result_t     got;
    result_t     want;
    int unsigned wait_n;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      stall_left <= 0;
      hold_taken <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = result_t'(m_axis_tdata[$bits(result_t)-1:0]);
        verdicts_seen++;
        if (verdict_q.size() == 0) begin
          $error("verdict beat with nothing expected: tdata %h", m_axis_tdata);
          errors++;
        end else begin
          want = verdict_q.pop_front();
          if (got.accepted) accepted_seen++;
          if (got.overlong) overlong_seen++;
          if (got.accepted !== want.accepted) begin
            $error("accepted: expected %0d, got %0d", want.accepted, got.accepted);
            errors++;
          end
          if (got.keep_start !== want.keep_start) begin
            $error("keep_start: expected %0d, got %0d", want.keep_start, got.keep_start);
            errors++;
          end
          if (got.keep_count !== want.keep_count) begin
            $error("keep_count: expected %0d, got %0d", want.keep_count, got.keep_count);
            errors++;
          end
          if (got.overlong !== want.overlong) begin
            $error("overlong: expected %0d, got %0d", want.overlong, got.overlong);
            errors++;
          end
        end
      end
      if (hold_req && !hold_taken) begin
        m_axis_tready <= 1'b0;
        stall_left <= HoldCycles;
        hold_taken <= 1'b1;
      end else if (m_axis_tvalid && m_axis_tready) begin
        wait_n = draw_wait(rx_idle_pct);
        m_axis_tready <= (wait_n == 0);
        stall_left <= (wait_n == 0) ? 0 : wait_n - 1;
      end else if (!m_axis_tready) begin
        if (stall_left > 0) stall_left <= stall_left - 1;
        else m_axis_tready <= 1'b1;
      end
    end
  end

  function automatic void push_point(logic [LabelW-1:0] lbl, bit last);
    point_t p;
    p.label = lbl;
    p.last = last;
    p.gap = draw_wait(tx_idle_pct);
    point_q.push_back(p);
    points_queued++;
  endfunction

  function automatic logic [LabelW-1:0] noise();
    return ($urandom_range(0, 2) == 0) ? lbl_reg[$urandom_range(0, 5)] : LabelW'($urandom);
  endfunction

  function automatic logic [LabelW-1:0] pick_label();
    case ($urandom_range(0, 5))
      0: return 16'h8000;
      1: return 16'h7fff;
      2, 3: return LabelW'($urandom_range(1, 3));
      default: return LabelW'($urandom);
    endcase
  endfunction

  // well-formed paths visit every label in order; broken ones skip or scramble
  function automatic void queue_path(bit proper);
    logic [LabelW-1:0] pts [$];
    int unsigned       n;
    n = eff_labels();
    repeat ($urandom_range(0, 2)) pts.push_back(noise());
    if (proper || $urandom_range(0, 2) != 0) begin
      repeat ($urandom_range(1, 3)) pts.push_back(lbl_reg[0]);
    end
    for (int k = 1; k < n; k++) begin
      if (!proper && $urandom_range(0, 3) == 0) continue;
      repeat ($urandom_range(0, 2)) pts.push_back(noise());
      pts.push_back(lbl_reg[k]);
    end
    repeat ($urandom_range(0, 2)) pts.push_back(noise());
    if (!proper && $urandom_range(0, 3) == 0) pts.shuffle();
    if (pts.size() == 0) pts.push_back(noise());
    foreach (pts[i]) push_point(pts[i], i == pts.size() - 1);
  endfunction

  task automatic write_reg(cfg_reg_e idx, logic [LabelW-1:0] d);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= d;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      REG_LABEL_COUNT: cnt_reg = d[CountCfgW-1:0];
      REG_CUT_MODE:    cut_reg = d[0];
      default:         lbl_reg[idx - REG_LABEL_A] = d;
    endcase
  endtask

  task automatic load_config(logic [CountCfgW-1:0] cnt, bit cut, logic [LabelW-1:0] l [6]);
    write_reg(REG_LABEL_COUNT, LabelW'(cnt));
    write_reg(REG_CUT_MODE, LabelW'(cut));
    for (int k = 0; k < 6; k++) write_reg(cfg_reg_e'(REG_LABEL_A + k), l[k]);
  endtask

  function automatic bit busy();
    return point_q.size() != 0 || s_axis_tvalid || verdict_q.size() != 0;
  endfunction

  // wait for all verdicts, then let the result register settle
  task automatic drain();
    for (int g = 0; g < 200000 && busy(); g++) @(negedge clk_i);
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  initial begin : stimulus
    logic [CountCfgW-1:0] count_seq [9];
    int unsigned          idle_mix [9];
    logic [LabelW-1:0]    lbls [6];
    int unsigned          goal;
    count_seq = '{3'd3, 3'd6, 3'd7, 3'd1, 3'd4, 3'd5, 3'd0, 3'd2, 3'd6};
    idle_mix = '{0, 30, 60, 90, 0, 20, 100, 50, 10};
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset defaults: all labels zero, two labels, whole path kept
    push_point(16'h1234, 1'b0);
    push_point(16'h0000, 1'b0);
    push_point(16'h7fff, 1'b0);
    push_point(16'h0000, 1'b1);
    push_point(16'h0000, 1'b1);
    push_point(16'h0000, 1'b0);
    push_point(16'h0000, 1'b1);
    drain();

    // extremes, leave-and-match on one point, wrong order, never entering
    load_config(3'd3, 1'b1, '{16'h8000, 16'h7fff, 16'hffff, 16'h0001, 16'h0002, 16'h0003});
    push_point(16'h8000, 1'b0);
    push_point(16'h7fff, 1'b0);
    push_point(16'h0000, 1'b0);
    push_point(16'hffff, 1'b0);
    push_point(16'h1111, 1'b1);
    push_point(16'h8000, 1'b0);
    push_point(16'hffff, 1'b0);
    push_point(16'h7fff, 1'b1);
    push_point(16'h7fff, 1'b0);
    push_point(16'hffff, 1'b1);
    drain();

    // count below range, final match without leaving the first region
    load_config(3'd0, 1'b1, '{16'h0005, 16'h0005, 16'h0000, 16'h0000, 16'h0000, 16'h0000});
    push_point(16'h0005, 1'b0);
    push_point(16'h0005, 1'b1);
    push_point(16'h0005, 1'b0);
    push_point(16'h0006, 1'b0);
    push_point(16'h0005, 1'b1);
    drain();

    for (int ph = 0; ph < 9; ph++) begin
      tx_idle_pct = idle_mix[ph];
      rx_idle_pct = idle_mix[(ph + 3) % 9];
      foreach (lbls[k]) lbls[k] = pick_label();
      load_config(count_seq[ph], ph[0], lbls);
      // output held off while the input keeps offering points
      if (ph == 4) begin
        rx_idle_pct = 0;
        hold_req = 1'b1;
      end
      goal = points_queued + 150;
      while (points_queued < goal) queue_path($urandom_range(0, 4) != 0);
      drain();
    end

    if (verdict_q.size() != 0) begin
      $error("%0d expected verdicts never arrived", verdict_q.size());
      errors++;
    end
    $display("sent %0d path points; checked %0d verdicts, %0d accepted, %0d overlong",
             points_sent, verdicts_seen, accepted_seen, overlong_seen);
    $display("label counts 0 to 7, both cut modes, random idles and a long output hold-off");
    if (errors == 0) begin
      $display("PASS ordered_region_waypoint_filter_unit");
    end else begin
      $display("FAIL ordered_region_waypoint_filter_unit");
    end
    $finish;
  end

  initial begin : watchdog
    #20_000_000;
    $display("FAIL ordered_region_waypoint_filter_unit");
    $finish;
  end

endmodule
